>>> design/npc_pkg.sv
// shared types, constants and helpers for the nearest palette color search
package npc_pkg;

  localparam int COMP_W = 8;
  localparam int IDX_W  = 6;
  localparam int DIST_W = 10;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } color_t;

  // transaction moving down the cell chain
  typedef struct packed {
    logic              valid;
    logic              action;
    logic [IDX_W-1:0]  entry_index;
    color_t            pixel;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_dist;
  } token_t;

  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [DIST_W-1:0] l1_dist(input color_t a, input color_t b);
    return DIST_W'(abs_diff(a.red, b.red)) + DIST_W'(abs_diff(a.green, b.green))
         + DIST_W'(abs_diff(a.blue, b.blue));
  endfunction

endpackage

>>> design/npc_if.sv
// valid/ready channel interfaces for pixel requests and index results
interface npc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [npc_pkg::IDX_W-1:0]  entry_index;
  logic [npc_pkg::COMP_W-1:0] red;
  logic [npc_pkg::COMP_W-1:0] green;
  logic [npc_pkg::COMP_W-1:0] blue;

  modport source (output valid, action, entry_index, red, green, blue, input ready);
  modport sink   (input valid, action, entry_index, red, green, blue, output ready);
endinterface

interface npc_out_if;
  logic                      valid;
  logic                      ready;
  logic [npc_pkg::IDX_W-1:0]  color_index;
  logic [npc_pkg::DIST_W-1:0] match_distance;

  modport source (output valid, color_index, match_distance, input ready);
  modport sink   (input valid, color_index, match_distance, output ready);
endinterface

>>> design/npc_cell.sv
// one chain cell: holds a palette entry and updates the running best match
module npc_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  npc_pkg::token_t tok_i,
  output npc_pkg::token_t tok_o
);
  import npc_pkg::*;

  color_t            entry_r;
  token_t            tok_r;
  token_t            tok_nxt;
  logic [DIST_W-1:0] cell_dist;
  logic              hit;

  assign cell_dist = l1_dist(tok_i.pixel, entry_r);
  assign hit  = tok_i.valid && (tok_i.action == ACT_WRITE) &&
                (9'(tok_i.entry_index) == 9'(IDX));

  always_comb begin
    tok_nxt = tok_i;
    // first cell always seeds the best, later cells take strictly smaller only
    if ((IDX == 0) || (cell_dist < tok_i.best_dist)) begin
      tok_nxt.best_idx  = IDX_W'(IDX);
      tok_nxt.best_dist = cell_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      entry_r <= tok_i.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (advance) begin
      tok_r.valid <= tok_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tok_r.action      <= tok_nxt.action;
      tok_r.entry_index <= tok_nxt.entry_index;
      tok_r.pixel       <= tok_nxt.pixel;
      tok_r.best_idx    <= tok_nxt.best_idx;
      tok_r.best_dist   <= tok_nxt.best_dist;
    end
  end

  assign tok_o = tok_r;

endmodule

>>> design/nearest_palette_color_search_top.sv
// nearest palette color search: a chain of cells, one per palette entry
// each cell registers the transaction on its way from acceptance to its result
// throughput: one transaction per cycle; the whole chain stalls while a result waits
// a palette write travels the chain in order and lands in its cell, giving no result
// reset clears the chain's valid flags only; palette entries are undefined until written
module nearest_palette_color_search_top #(
  parameter int PALETTE_ENTRIES = 64
) (
  input logic      clk,
  input logic      rst_n,
  npc_in_if.sink   in_if,
  npc_out_if.source out_if
);
  import npc_pkg::*;

  token_t tok [PALETTE_ENTRIES+1];
  logic   advance;

  assign advance     = !(out_if.valid && !out_if.ready);
  assign in_if.ready = advance;

  always_comb begin
    tok[0].valid       = in_if.valid;
    tok[0].action      = in_if.action;
    tok[0].entry_index = in_if.entry_index;
    tok[0].pixel.red   = in_if.red;
    tok[0].pixel.green = in_if.green;
    tok[0].pixel.blue  = in_if.blue;
    tok[0].best_idx    = '0;
    tok[0].best_dist   = '0;
  end

  for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
    npc_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
  end

  // write transactions drop off the end of the chain
  assign out_if.valid          = tok[PALETTE_ENTRIES].valid &&
                                 (tok[PALETTE_ENTRIES].action == ACT_LOOKUP);
  assign out_if.color_index    = tok[PALETTE_ENTRIES].best_idx;
  assign out_if.match_distance = tok[PALETTE_ENTRIES].best_dist;

endmodule

>>> design/npc_checker.sv
// port-level checks for the nearest palette color search, bound to the top level
module npc_port_assert (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [npc_pkg::IDX_W-1:0]  color_index,
  input logic [npc_pkg::DIST_W-1:0] match_distance
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while a result is stalled");

  a_free_takes_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with an empty output stage");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (match_distance <= 10'd765))
    else $error("distance beyond three full component differences");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(color_index) && $stable(match_distance)))
    else $error("stalled result changed");

endmodule

bind nearest_palette_color_search_top npc_port_assert u_npc_port_assert (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .color_index    (out_if.color_index),
  .match_distance (out_if.match_distance)
);

>>> tb/npc_checker.sv
// scoreboard for the nearest palette color search: predicts each lookup and checks every result
`timescale 1ns / 1ps

module npc_checker #(
  parameter int PALETTE_ENTRIES = 64
) (
  input  logic clk,
  input  logic rst_n,
  npc_in_if    in_ch,
  npc_out_if   out_ch,
  output int   errors,
  output int   pending
);
  import npc_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  color_index;
    logic [DIST_W-1:0] match_distance;
  } match_t;

  color_t palette [PALETTE_ENTRIES];
  match_t due_matches [$];
  int     fail_cnt = 0;

  initial begin
    foreach (palette[i]) palette[i] = '0;
  end

  function automatic int comp_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // lowest index wins a tie, so only a strictly smaller sum replaces the best
  function automatic match_t nearest_entry(input color_t px);
    match_t best;
    int     d;
    int     best_d;
    best   = '0;
    best_d = 0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      d = comp_gap(int'(px.red), int'(palette[i].red))
        + comp_gap(int'(px.green), int'(palette[i].green))
        + comp_gap(int'(px.blue), int'(palette[i].blue));
      if (i == 0 || d < best_d) begin
        best.color_index    = IDX_W'(i);
        best.match_distance = DIST_W'(d);
        best_d              = d;
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin : watch
    match_t want;
    color_t px;
    if (!rst_n) begin
      due_matches.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_matches.size() == 0) begin
          $display("%0t: result with no lookup outstanding: color_index %0d match_distance %0d",
                   $time, out_ch.color_index, out_ch.match_distance);
          fail_cnt++;
        end else begin
          want = due_matches.pop_front();
          if (out_ch.color_index !== want.color_index) begin
            $display("%0t: color_index mismatch: expected %0d, actual %0d",
                     $time, want.color_index, out_ch.color_index);
            fail_cnt++;
          end
          if (out_ch.match_distance !== want.match_distance) begin
            $display("%0t: match_distance mismatch: expected %0d, actual %0d",
                     $time, want.match_distance, out_ch.match_distance);
            fail_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        px = '{red: in_ch.red, green: in_ch.green, blue: in_ch.blue};
        if (in_ch.action == ACT_WRITE) begin
          if (int'(in_ch.entry_index) < PALETTE_ENTRIES) palette[in_ch.entry_index] = px;
        end else begin
          due_matches.push_back(nearest_entry(px));
        end
      end
    end
    errors  <= fail_cnt;
    pending <= due_matches.size();
  end

endmodule

>>> tb/tb.sv
// testbench top: clock, reset, palette and pixel stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb;
  import npc_pkg::*;

  localparam int PALETTE_ENTRIES = 64;
  localparam int PHASE_ITEMS     = 420;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = PALETTE_ENTRIES + 32;

  localparam color_t BLACK = '{red: 8'h00, green: 8'h00, blue: 8'h00};
  localparam color_t WHITE = '{red: 8'hff, green: 8'hff, blue: 8'hff};
  localparam color_t GRAY  = '{red: 8'h80, green: 8'h80, blue: 8'h80};

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   hold_off = 1'b0;
  int     in_idle_pct = 0;
  int     out_idle_pct = 0;
  int     quiet_cycles = 0;
  int     errors;
  int     pending;
  color_t shadow [PALETTE_ENTRIES];

  npc_in_if  in_ch ();
  npc_out_if out_ch ();

  nearest_palette_color_search_top #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  npc_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // restarts on every transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("nearest_palette_color_search_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [COMP_W-1:0] rand_comp();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hff : 8'h00;
    return COMP_W'($urandom);
  endfunction

  function automatic color_t rand_color();
    color_t c;
    c.red   = rand_comp();
    c.green = rand_comp();
    c.blue  = rand_comp();
    return c;
  endfunction

  function automatic logic [COMP_W-1:0] jitter(input logic [COMP_W-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(16)) - 8;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return COMP_W'(t);
  endfunction

  // exact hits and near misses of palette entries, extremes, or anything
  function automatic color_t pick_pixel();
    color_t c;
    c = shadow[$urandom_range(PALETTE_ENTRIES - 1)];
    case ($urandom_range(9))
      0: ;
      1, 2: begin
        c.red   = jitter(c.red);
        c.green = jitter(c.green);
        c.blue  = jitter(c.blue);
      end
      3: c = '{red: {8{$urandom_range(1) == 1}}, green: {8{$urandom_range(1) == 1}},
               blue: {8{$urandom_range(1) == 1}}};
      default: c = rand_color();
    endcase
    return c;
  endfunction

  task automatic send(input logic act, input logic [IDX_W-1:0] idx, input color_t c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.entry_index <= idx;
    in_ch.red         <= c.red;
    in_ch.green       <= c.green;
    in_ch.blue        <= c.blue;
    if (act == ACT_WRITE) shadow[idx] = c;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic run_phase(input int in_pct, input int out_pct, input bit with_hold);
    color_t seeds [4];
    int     n_seeds;
    in_idle_pct = in_pct;
    out_idle_pct <= out_pct;
    if (with_hold) begin
      fork
        begin
          hold_off <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_off <= 1'b0;
        end
      join_none
    end
    // reload from a few colors so that ties and long distances are common
    foreach (seeds[i]) seeds[i] = rand_color();
    n_seeds = $urandom_range(1, 4);
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      send(ACT_WRITE, IDX_W'(i), seeds[$urandom_range(n_seeds - 1)]);
    end
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        send(ACT_WRITE, IDX_W'($urandom),
             $urandom_range(1) ? shadow[$urandom_range(PALETTE_ENTRIES - 1)] : rand_color());
      end else begin
        send(ACT_LOOKUP, IDX_W'($urandom), pick_pixel());
      end
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_LOOKUP;
    in_ch.entry_index = '0;
    in_ch.red         = '0;
    in_ch.green       = '0;
    in_ch.blue        = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // all white: the first two lookups tie across the whole palette, later writes break the tie
    for (int i = 0; i < PALETTE_ENTRIES; i++) send(ACT_WRITE, IDX_W'(i), WHITE);
    send(ACT_LOOKUP, '0, BLACK);
    send(ACT_LOOKUP, '1, WHITE);
    send(ACT_WRITE, IDX_W'(PALETTE_ENTRIES - 1), BLACK);
    send(ACT_LOOKUP, '0, BLACK);
    send(ACT_LOOKUP, '0, '{red: 8'h00, green: 8'h00, blue: 8'h01});
    send(ACT_WRITE, 6'd32, GRAY);
    send(ACT_WRITE, 6'd33, GRAY);
    send(ACT_LOOKUP, '0, GRAY);
    send(ACT_LOOKUP, '0, '{red: 8'h80, green: 8'h80, blue: 8'h81});
    send(ACT_LOOKUP, '0, '{red: 8'h00, green: 8'hff, blue: 8'h00});
    send(ACT_WRITE, 6'd0, '{red: 8'hff, green: 8'h00, blue: 8'h00});
    send(ACT_LOOKUP, '0, '{red: 8'hff, green: 8'h00, blue: 8'h00});
    send(ACT_LOOKUP, '0, '{red: 8'h7f, green: 8'h7f, blue: 8'h7f});

    run_phase(10, 82, 1'b0);
    run_phase(82, 10, 1'b0);
    run_phase(0, 0, 1'b1);
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("nearest_palette_color_search_top verification clean");
    end else begin
      if (pending != 0) $display("%0t: %0d lookups never answered", $time, pending);
      $display("nearest_palette_color_search_top verification failed");
    end
    $finish;
  end

endmodule
